// ===== rtl/ihex_pkg.sv =====
// Shared types, constants and helper functions for the HEX record parser.
// No dependencies; used by every other file in rtl.
`default_nettype none

package ihex_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } char_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_offset;
    logic [15:0] address;
    logic [7:0]  payload_len;
    logic [2:0]  status;
    logic        last;
  } result_t;

  localparam logic [7:0] MAX_PAYLOAD = 8'd255;
  localparam logic [9:0] INDEX_MAX   = 10'd1023;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;

  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_LIN   = 8'h04;
  localparam logic [7:0] REC_START_LIN = 8'h05;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_DATA      = 3'd0;
  localparam logic [2:0] ST_EOF       = 3'd1;
  localparam logic [2:0] ST_EXT_LIN   = 3'd2;
  localparam logic [2:0] ST_START_LIN = 3'd3;
  localparam logic [2:0] ST_BAD_START = 3'd4;
  localparam logic [2:0] ST_BAD_SUM   = 3'd5;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd6;
  localparam logic [2:0] ST_FORMAT    = 3'd7;

  // Bit 4 set means the character is not a hex digit; the nibble is then zero.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic logic [2:0] type_status(input logic [7:0] t);
    logic [2:0] r;
    unique case (t)
      REC_DATA:      r = ST_DATA;
      REC_EOF:       r = ST_EOF;
      REC_EXT_LIN:   r = ST_EXT_LIN;
      REC_START_LIN: r = ST_START_LIN;
      default:       r = ST_BAD_TYPE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ihex_line.sv =====
// Per-line decode state and the single-pass character decode.
// Depends on ihex_pkg.
`default_nettype none

module ihex_line (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire ihex_pkg::char_t   item,
  output logic                   push,
  output ihex_pkg::result_t      result
);

  logic [9:0]  char_index, char_index_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  byte_sum, byte_sum_next;
  logic [7:0]  length_field, length_field_next;
  logic [15:0] address_field, address_field_next;
  logic [7:0]  type_field, type_field_next;
  logic        err_start, err_start_next;
  logic        err_format, err_format_next;

  logic [4:0]  hex;
  logic [3:0]  nib;
  logic [7:0]  val;
  logic [9:0]  idx_m2;
  logic [8:0]  b;
  logic [8:0]  off;
  logic        have_data;
  logic        len_bad;
  logic [2:0]  st;

  always_comb begin
    hex    = ihex_pkg::hex_value(item.ch);
    nib    = hex[3:0];
    val    = {high_nibble, nib};
    idx_m2 = char_index - 10'd2;
    b      = idx_m2[9:1];
    off    = b - 9'd4;

    char_index_next    = char_index;
    high_nibble_next   = high_nibble;
    byte_sum_next      = byte_sum;
    length_field_next  = length_field;
    address_field_next = address_field;
    type_field_next    = type_field;
    err_start_next     = err_start;
    err_format_next    = err_format;
    have_data          = 1'b0;

    if (char_index == 10'd0) begin
      if (item.ch != ihex_pkg::CHAR_COLON) err_start_next = 1'b1;
    end else if (char_index != ihex_pkg::INDEX_MAX) begin
      if (hex[4]) err_format_next = 1'b1;
      if (char_index[0]) begin
        high_nibble_next = nib;
      end else begin
        byte_sum_next = byte_sum + val;
        if (b == 9'd0) begin
          length_field_next = val;
          if (val > ihex_pkg::MAX_PAYLOAD) err_format_next = 1'b1;
        end else if (b == 9'd1) begin
          address_field_next = {val, 8'h00};
        end else if (b == 9'd2) begin
          address_field_next = {address_field[15:8], val};
        end else if (b == 9'd3) begin
          type_field_next = val;
        end else if (off < {1'b0, length_field} &&
                     (type_field == ihex_pkg::REC_DATA ||
                      type_field == ihex_pkg::REC_EXT_LIN)) begin
          have_data = 1'b1;
        end
      end
    end

    if (char_index != ihex_pkg::INDEX_MAX) char_index_next = char_index + 10'd1;

    len_bad = {1'b0, char_index} != (11'd10 + {2'b00, length_field_next, 1'b0});

    if (err_start_next) st = ihex_pkg::ST_BAD_START;
    else if (err_format_next || len_bad) st = ihex_pkg::ST_FORMAT;
    else if (byte_sum_next != 8'd0) st = ihex_pkg::ST_BAD_SUM;
    else st = ihex_pkg::type_status(type_field_next);

    result.address     = address_field_next;
    result.payload_len = length_field_next;
    if (item.line_end) begin
      result.kind        = ihex_pkg::KIND_STATUS;
      result.data_byte   = 8'd0;
      result.byte_offset = 8'd0;
      result.status      = st;
      result.last        = 1'b1;
    end else begin
      result.kind        = ihex_pkg::KIND_DATA;
      result.data_byte   = val;
      result.byte_offset = off[7:0];
      result.status      = ihex_pkg::ST_DATA;
      result.last        = 1'b0;
    end

    push = accept && (item.line_end || have_data);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.line_end)) begin
      char_index    <= '0;
      high_nibble   <= '0;
      byte_sum      <= '0;
      length_field  <= '0;
      address_field <= '0;
      type_field    <= '0;
      err_start     <= 1'b0;
      err_format    <= 1'b0;
    end else if (accept) begin
      char_index    <= char_index_next;
      high_nibble   <= high_nibble_next;
      byte_sum      <= byte_sum_next;
      length_field  <= length_field_next;
      address_field <= address_field_next;
      type_field    <= type_field_next;
      err_start     <= err_start_next;
      err_format    <= err_format_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ihex_obuf.sv =====
// Result register with a skid stage that holds one result while out is stalled.
// Depends on ihex_pkg.
`default_nettype none

module ihex_obuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ihex_pkg::result_t push_item,
  output logic                   can_push,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ihex_pkg::result_t      out_item
);

  logic              skid_valid;
  ihex_pkg::result_t skid_item;
  logic              out_free;

  assign can_push = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_item <= skid_item;
      else if (push) out_item <= push_item;
    end else if (push) begin
      skid_item <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/intel_hex_record_parser.sv =====
// Top level of the HEX record parser: line decode followed by the result buffer.
// Depends on ihex_pkg, ihex_line and ihex_obuf.
//
// Usage: one ASCII character of a record line enters per item on the char
// channel, colon first, with line_end set on the final character. Each payload
// byte of a data or extended-linear-address record leaves on the res channel
// as soon as its second digit is taken; the flagged last character produces
// one status item carrying address, length and the record status. Data bytes
// of a line whose status is an error must be discarded by the receiver.
// A result reaches res through the result register, or the skid entry if stalled.
// Throughput: one character per cycle while char_ready is high; the decode is a
// single pass between the line state registers and the result register.
// Stall: a result register plus one skid entry hold up to two results, so a
// character is still taken in the first stalled cycle; char_ready drops only
// while the skid entry is occupied.
// Reset: clears the line state and empties both result entries; the next
// character is taken as the first of a line.
`default_nettype none

module intel_hex_record_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              char_valid,
  output logic                   char_ready,
  input  wire ihex_pkg::char_t   char_item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output ihex_pkg::result_t      res_item
);

  logic              accept;
  logic              push;
  ihex_pkg::result_t result;

  assign accept = char_valid && char_ready;

  ihex_line u_line (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (char_item),
    .push   (push),
    .result (result)
  );

  ihex_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (result),
    .can_push  (char_ready),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_item  (res_item)
  );

endmodule

`default_nettype wire

// ===== rtl/ihex_checker.sv =====
// Port-level checks on the HEX record parser, bound to its top level.
// Depends on ihex_pkg and intel_hex_record_parser.
`default_nettype none

module ihex_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              char_valid,
  input wire logic              char_ready,
  input wire ihex_pkg::char_t   char_item,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire ihex_pkg::result_t res_item
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result item changed while stalled");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_ready && char_item.line_end |=> res_valid)
    else $error("line end produced no result item");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.kind == res_item.last)
    else $error("last flag disagrees with item kind");

  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind == ihex_pkg::KIND_DATA |->
      res_item.status == ihex_pkg::ST_DATA &&
      res_item.byte_offset < res_item.payload_len)
    else $error("data item with bad status or offset");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .char_item  (char_item),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res_item   (res_item)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for intel_hex_record_parser: feeds record lines one
// character per item and checks every data byte and line status it returns.
// Depends on rtl/ihex_pkg.sv and the parser RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT   = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int SATURATED_LEN  = 1030;

  class hex_line_scoreboard;
    logic [9:0]  char_index;
    logic [3:0]  high_nib;
    logic [7:0]  byte_sum;
    logic [7:0]  rec_len;
    logic [15:0] rec_addr;
    logic [7:0]  rec_type;
    bit          start_err;
    bit          format_err;
    ihex_pkg::result_t expected_q[$];
    int          mismatches;
    int          data_results;
    int          status_hist[8];

    function new();
      clear_line();
    endfunction

    function void clear_line();
      char_index = '0;
      high_nib   = '0;
      byte_sum   = '0;
      rec_len    = '0;
      rec_addr   = '0;
      rec_type   = '0;
      start_err  = 1'b0;
      format_err = 1'b0;
    endfunction

    // Bit 4 flags a character that is not a hex digit.
    function logic [4:0] digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b0, c[3:0] + 4'd9};
      return 5'h10;
    endfunction

    function logic [2:0] line_status();
      if (start_err) return ihex_pkg::ST_BAD_START;
      if (format_err) return ihex_pkg::ST_FORMAT;
      if (byte_sum != 8'h00) return ihex_pkg::ST_BAD_SUM;
      case (rec_type)
        ihex_pkg::REC_DATA:      return ihex_pkg::ST_DATA;
        ihex_pkg::REC_EOF:       return ihex_pkg::ST_EOF;
        ihex_pkg::REC_EXT_LIN:   return ihex_pkg::ST_EXT_LIN;
        ihex_pkg::REC_START_LIN: return ihex_pkg::ST_START_LIN;
        default:                 return ihex_pkg::ST_BAD_TYPE;
      endcase
    endfunction

    function void note_char(input ihex_pkg::char_t c);
      int                idx;
      int                pos;
      logic [4:0]        dv;
      logic [7:0]        val;
      bit                emit;
      ihex_pkg::result_t r;
      idx  = char_index;
      emit = 1'b0;
      r    = '0;
      if (idx == 0) begin
        if (c.ch != ihex_pkg::CHAR_COLON) start_err = 1'b1;
      end else if (idx < ihex_pkg::INDEX_MAX) begin
        dv = digit_value(c.ch);
        if (dv[4]) begin
          format_err = 1'b1;
          dv = 5'd0;
        end
        if (idx % 2 == 1) begin
          high_nib = dv[3:0];
        end else begin
          pos = (idx - 2) / 2;
          val = {high_nib, dv[3:0]};
          byte_sum = byte_sum + val;
          case (pos)
            0: begin
              rec_len = val;
              if (val > ihex_pkg::MAX_PAYLOAD) format_err = 1'b1;
            end
            1: rec_addr = {val, 8'h00};
            2: rec_addr[7:0] = val;
            3: rec_type = val;
            default: begin
              if (pos - 4 < int'(rec_len) &&
                  (rec_type == ihex_pkg::REC_DATA ||
                   rec_type == ihex_pkg::REC_EXT_LIN)) begin
                emit = 1'b1;
                r.data_byte = val;
                r.byte_offset = 8'(pos - 4);
              end
            end
          endcase
        end
      end
      if (char_index < ihex_pkg::INDEX_MAX) char_index = char_index + 10'd1;
      if (c.line_end) begin
        if (idx != 10 + 2 * int'(rec_len)) format_err = 1'b1;
        r = '0;
        r.kind        = ihex_pkg::KIND_STATUS;
        r.address     = rec_addr;
        r.payload_len = rec_len;
        r.status      = line_status();
        r.last        = 1'b1;
        expected_q.push_back(r);
        clear_line();
      end else if (emit) begin
        r.kind        = ihex_pkg::KIND_DATA;
        r.address     = rec_addr;
        r.payload_len = rec_len;
        r.status      = ihex_pkg::ST_DATA;
        r.last        = 1'b0;
        expected_q.push_back(r);
      end
    endfunction

    function string show(input ihex_pkg::result_t r);
      return $sformatf("kind=%0d byte=%02h off=%0d addr=%04h len=%0d status=%0d last=%0d",
                       r.kind, r.data_byte, r.byte_offset, r.address, r.payload_len,
                       r.status, r.last);
    endfunction

    function void check_result(input ihex_pkg::result_t got);
      ihex_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("Unexpected result: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.byte_offset !== want.byte_offset || got.address !== want.address ||
          got.payload_len !== want.payload_len || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Mismatch, expected: %s", show(want));
          $display("          actual:   %s", show(got));
        end
      end
      if (want.kind == ihex_pkg::KIND_STATUS) status_hist[want.status]++;
      else data_results++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              char_valid = 1'b0;
  logic              char_ready;
  ihex_pkg::char_t   char_item = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  ihex_pkg::result_t res_item;

  hex_line_scoreboard sb = new();

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_start = 1'b0;
  int         hold_cnt = 0;
  int         chars_sent = 0;
  int         stalled_cycles = 0;
  int         quiet_cycles = 0;
  logic [7:0] line_buf[$];

  intel_hex_record_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_start && hold_cnt < HOLD_CYCLES) begin
      res_ready <= 1'b0;
      hold_cnt++;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) sb.check_result(res_item);
      if (char_valid && char_ready) sb.note_char(char_item);
      if (char_valid && !char_ready) stalled_cycles++;
      if ((res_valid && res_ready) || (char_valid && char_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return "0" + n;
    return (lower ? "a" : "A") + n - 8'd10;
  endfunction

  // Builds a complete record into line_buf; a nonzero sum_adjust spoils the checksum.
  task automatic build_record(input int len, input logic [7:0] rtype, input logic [15:0] addr,
                              input bit lower, input logic [7:0] sum_adjust);
    logic [7:0] rec[$];
    logic [7:0] sum;
    rec = {};
    rec.push_back(8'(len));
    rec.push_back(addr[15:8]);
    rec.push_back(addr[7:0]);
    rec.push_back(rtype);
    repeat (len) rec.push_back(8'($urandom_range(0, 255)));
    sum = 8'h00;
    foreach (rec[i]) sum = sum + rec[i];
    rec.push_back(8'h00 - sum + sum_adjust);
    line_buf = {};
    line_buf.push_back(ihex_pkg::CHAR_COLON);
    foreach (rec[i]) begin
      line_buf.push_back(nibble_char(rec[i][7:4], lower));
      line_buf.push_back(nibble_char(rec[i][3:0], lower));
    end
  endtask

  task automatic send_char(input logic [7:0] c, input bit is_end);
    ihex_pkg::char_t item;
    item.ch = c;
    item.line_end = is_end;
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_item <= item;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  // Mostly well-formed records with random content, the rest broken or noise.
  task automatic make_random_line();
    int         len;
    int         pick;
    int         k;
    logic [7:0] rtype;
    logic [7:0] c;
    logic [4:0] dv;
    pick = $urandom_range(99);
    if (pick < 80) len = $urandom_range(0, 16);
    else if (pick < 97) len = $urandom_range(17, 48);
    else len = $urandom_range(49, 255);
    pick = $urandom_range(99);
    if (pick < 55) rtype = ihex_pkg::REC_DATA;
    else if (pick < 65) rtype = ihex_pkg::REC_EOF;
    else if (pick < 75) rtype = ihex_pkg::REC_EXT_LIN;
    else if (pick < 85) rtype = ihex_pkg::REC_START_LIN;
    else rtype = 8'($urandom_range(0, 255));
    build_record(len, rtype, 16'($urandom_range(0, 65535)), 1'($urandom_range(1)), 8'h00);
    pick = $urandom_range(99);
    if (pick < 70) begin
    end else if (pick < 75) begin
      c = 8'($urandom_range(0, 255));
      if (c == ihex_pkg::CHAR_COLON) c = 8'h00;
      line_buf[0] = c;
    end else if (pick < 82) begin
      build_record(len, rtype, 16'($urandom_range(0, 65535)), 1'b0,
                   8'($urandom_range(1, 255)));
    end else if (pick < 88) begin
      k = $urandom_range(1, line_buf.size() - 1);
      c = 8'($urandom_range(0, 255));
      dv = sb.digit_value(c);
      if (!dv[4]) c = c ^ 8'h80;
      line_buf[k] = c;
    end else if (pick < 93) begin
      k = $urandom_range(1, 3);
      repeat (k) void'(line_buf.pop_back());
    end else if (pick < 97) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(nibble_char(4'($urandom_range(15)), 1'b0));
    end else begin
      line_buf = {};
      repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_lines_until(input int target);
    while (chars_sent < target) begin
      make_random_line();
      send_line();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    recv_idle_pct <= 76;

    build_record(0, ihex_pkg::REC_EOF, 16'h0000, 1'b0, 8'h00);
    send_line();
    build_record(1, ihex_pkg::REC_DATA, 16'hFFFF, 1'b1, 8'h00);
    send_line();
    build_record(2, ihex_pkg::REC_EXT_LIN, 16'h0000, 1'b0, 8'h00);
    send_line();
    build_record(4, ihex_pkg::REC_START_LIN, 16'h0000, 1'b0, 8'h00);
    send_line();
    build_record(2, 8'h02, 16'h0100, 1'b0, 8'h00);
    send_line();
    build_record(0, 8'hFF, 16'h0000, 1'b1, 8'h00);
    send_line();
    build_record(3, ihex_pkg::REC_DATA, 16'h1234, 1'b0, 8'h00);
    line_buf[0] = 8'h00;
    send_line();
    build_record(2, ihex_pkg::REC_DATA, 16'h8000, 1'b0, 8'h01);
    send_line();
    build_record(2, ihex_pkg::REC_DATA, 16'h0010, 1'b0, 8'h00);
    line_buf[10] = 8'hFF;
    send_line();
    build_record(3, ihex_pkg::REC_DATA, 16'h0000, 1'b0, 8'h00);
    while (line_buf.size() > 13) void'(line_buf.pop_back());
    send_line();
    build_record(1, ihex_pkg::REC_EXT_LIN, 16'h0000, 1'b0, 8'h00);
    void'(line_buf.pop_back());
    send_line();
    build_record(0, ihex_pkg::REC_EOF, 16'h0000, 1'b0, 8'h00);
    line_buf.push_back("0");
    send_line();
    line_buf = {ihex_pkg::CHAR_COLON};
    send_line();
    line_buf = {8'h41};
    send_line();

    random_lines_until(450);

    send_idle_pct = 76;
    recv_idle_pct <= 15;
    random_lines_until(900);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_start <= 1'b1;
    build_record(64, ihex_pkg::REC_DATA, 16'h4000, 1'b0, 8'h00);
    send_line();
    build_record(255, ihex_pkg::REC_DATA, 16'($urandom_range(0, 65535)), 1'b0, 8'h00);
    while (line_buf.size() < SATURATED_LEN)
      line_buf.push_back(nibble_char(4'($urandom_range(15)), 1'b0));
    send_line();
    random_lines_until(chars_sent + 100);

    char_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters; checked %0d data bytes; input held back for %0d cycles.",
             chars_sent, sb.data_results, stalled_cycles);
    $display({"Line statuses seen (data, eof, ext, start, start err, sum, type, format):",
              " %0d %0d %0d %0d %0d %0d %0d %0d"},
             sb.status_hist[0], sb.status_hist[1], sb.status_hist[2], sb.status_hist[3],
             sb.status_hist[4], sb.status_hist[5], sb.status_hist[6], sb.status_hist[7]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
